[rtl/core/pri_pkg.sv]
// ----------------------------------------------------------------------------
// pri_pkg
// Shared types and constants of the particle repulsion integrator.
// ----------------------------------------------------------------------------
package pri_pkg;

  typedef enum logic [1:0] {
    KIND_BEGIN    = 2'd0,
    KIND_NEIGHBOR = 2'd1,
    KIND_FINISH   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_RADIUS   = 3'd0,
    REG_STRENGTH = 3'd1,
    REG_DAMPING  = 3'd2,
    REG_STEP_DT  = 3'd3,
    REG_MAX_STEP = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    ARITH_MUL  = 2'd0,
    ARITH_DIV  = 2'd1,
    ARITH_SQRT = 2'd2
  } arith_op_e;

  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

  localparam logic [5:0]  MUL_LAST  = 6'd31;
  localparam logic [5:0]  DIV_LAST  = 6'd63;
  localparam logic [5:0]  SQRT_LAST = 6'd31;
  localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

  localparam logic [30:0] RADIUS_RST   = 31'd65536;
  localparam logic [30:0] STRENGTH_RST = 31'd65536;
  localparam logic [16:0] DAMPING_RST  = 17'd65536;
  localparam logic [30:0] STEP_DT_RST  = 31'd6554;
  localparam logic [30:0] MAX_STEP_RST = 31'd65536;

  typedef struct packed {
    logic [30:0] radius;
    logic [30:0] strength;
    logic [16:0] damping;
    logic [30:0] step_dt;
    logic [30:0] max_step;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [17:0] norm_x;
    logic signed [17:0] norm_y;
    logic signed [17:0] norm_z;
  } item_t;

  typedef struct packed {
    logic      start;
    arith_op_e op;
    logic [63:0] a;
    logic [63:0] b;
  } arith_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [95:0] res;
  } arith_rsp_t;

endpackage

[rtl/core/pri_if.sv]
// ----------------------------------------------------------------------------
// pri_if
// Input and output item channels of the particle repulsion integrator.
// ----------------------------------------------------------------------------
interface pri_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic signed [17:0] norm_x;
  logic signed [17:0] norm_y;
  logic signed [17:0] norm_z;

  modport source (output valid, kind, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  norm_x, norm_y, norm_z, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  norm_x, norm_y, norm_z, output ready);
endinterface

interface pri_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_pos_z;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic signed [31:0] new_vel_z;

  modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                  new_vel_z, input ready);
  modport sink   (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                  new_vel_z, output ready);
endinterface

[rtl/core/pri_arith.sv]
// ----------------------------------------------------------------------------
// pri_arith
// Shared iterative unit: shift-add multiply, restoring divide, integer root.
// ----------------------------------------------------------------------------
module pri_arith import pri_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  arith_req_t req_i,
  output arith_rsp_t rsp_o
);

  logic        busy_q, busy_d, done_q, done_d;
  arith_op_e   op_q, op_d;
  logic [5:0]  cnt_q, cnt_d, last_cnt;
  logic [95:0] acc_q, acc_d;
  logic [63:0] opa_q, opa_d, opb_q, opb_d, aux_q, aux_d, rem_q, rem_d;
  logic [64:0] mul_sum, div_sh, div_diff;
  logic        div_ge, sq_ge;
  logic [63:0] sq_trial;

  assign mul_sum  = {1'b0, acc_q[95:32]} + (acc_q[0] ? {1'b0, opa_q} : 65'd0);
  assign div_sh   = {rem_q, aux_q[63]};
  assign div_ge   = div_sh >= {1'b0, opb_q};
  assign div_diff = div_sh - {1'b0, opb_q};
  assign sq_trial = acc_q[63:0] + opa_q;
  assign sq_ge    = aux_q >= sq_trial;

  always_comb begin
    case (op_q)
      ARITH_DIV:  last_cnt = DIV_LAST;
      ARITH_SQRT: last_cnt = SQRT_LAST;
      default:    last_cnt = MUL_LAST;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    opa_d  = opa_q;
    opb_d  = opb_q;
    aux_d  = aux_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = '0;
      opa_d  = req_i.a;
      opb_d  = req_i.b;
      unique case (req_i.op)
        ARITH_MUL: acc_d = {64'd0, req_i.b[31:0]};
        ARITH_DIV: begin
          aux_d = req_i.a;
          rem_d = '0;
        end
        ARITH_SQRT: begin
          aux_d = req_i.a;
          acc_d = '0;
          opa_d = SQRT_BIT0;
        end
        default: ;
      endcase
    end else if (busy_q) begin
      case (op_q)
        ARITH_DIV: begin
          rem_d = div_ge ? div_diff[63:0] : div_sh[63:0];
          aux_d = {aux_q[62:0], div_ge};
        end
        ARITH_SQRT: begin
          acc_d = {32'd0, (sq_ge ? ((acc_q[63:0] >> 1) + opa_q) : (acc_q[63:0] >> 1))};
          aux_d = sq_ge ? (aux_q - sq_trial) : aux_q;
          opa_d = opa_q >> 2;
        end
        default: acc_d = {mul_sum, acc_q[31:1]};
      endcase
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == last_cnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= ARITH_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
    aux_q <= aux_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res  = (op_q == ARITH_MUL) ? acc_q :
                      {32'd0, ((op_q == ARITH_DIV) ? aux_q : acc_q[63:0])};

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("arith done without a running operation");

endmodule

[rtl/core/pri_front.sv]
// ----------------------------------------------------------------------------
// pri_front
// Accepts items, drops unknown kinds and queues the rest for the back end.
// ----------------------------------------------------------------------------
module pri_front import pri_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  pri_in_if.sink   in_i,
  output logic     item_valid_o,
  output item_t    item_o,
  input  logic     item_ready_i
);

  localparam logic [QUEUE_AW:0] QueueFull = (QUEUE_AW + 1)'(QUEUE_DEPTH);

  item_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]   cnt_q;
  logic                kind_ok, push, pop;
  item_t               in_item;

  always_comb begin
    unique case (in_i.kind)
      KIND_BEGIN, KIND_NEIGHBOR, KIND_FINISH: kind_ok = 1'b1;
      default:                                kind_ok = 1'b0;
    endcase
  end

  assign in_item.kind   = kind_e'(in_i.kind);
  assign in_item.pos_x  = in_i.pos_x;
  assign in_item.pos_y  = in_i.pos_y;
  assign in_item.pos_z  = in_i.pos_z;
  assign in_item.vel_x  = in_i.vel_x;
  assign in_item.vel_y  = in_i.vel_y;
  assign in_item.vel_z  = in_i.vel_z;
  assign in_item.norm_x = in_i.norm_x;
  assign in_item.norm_y = in_i.norm_y;
  assign in_item.norm_z = in_i.norm_z;

  assign in_i.ready   = cnt_q != QueueFull;
  assign push         = in_i.valid && in_i.ready && kind_ok;
  assign item_valid_o = cnt_q != '0;
  assign item_o       = mem_q[rd_ptr_q];
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_item;
  end

  a_fill_tracks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue fill count lost a pushed item");

endmodule

[rtl/core/pri_back.sv]
// ----------------------------------------------------------------------------
// pri_back
// Sequencer that carries out queued items on the shared arithmetic unit.
// ----------------------------------------------------------------------------
module pri_back import pri_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      item_valid_i,
  input  item_t     item_i,
  output logic      item_ready_o,
  pri_out_if.source out_o
);

  typedef enum logic [19:0] {
    ST_IDLE    = 20'h00001,
    ST_N_SQ    = 20'h00002,
    ST_N_RR    = 20'h00004,
    ST_N_SQRT  = 20'h00008,
    ST_N_X     = 20'h00010,
    ST_N_KX    = 20'h00020,
    ST_N_KXX   = 20'h00040,
    ST_N_G     = 20'h00080,
    ST_N_ACC   = 20'h00100,
    ST_F_VEL   = 20'h00200,
    ST_F_DOT   = 20'h00400,
    ST_F_NRM   = 20'h00800,
    ST_F_P     = 20'h01000,
    ST_F_SHIFT = 20'h02000,
    ST_F_LEN   = 20'h04000,
    ST_F_LIM   = 20'h08000,
    ST_F_SQRT  = 20'h10000,
    ST_F_SC    = 20'h20000,
    ST_F_DIV   = 20'h40000,
    ST_F_OUT   = 20'h80000
  } state_e;

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    mag32 = x[31] ? 32'(-x) : 32'(x);
  endfunction

  function automatic logic [17:0] mag18(input logic signed [17:0] x);
    mag18 = x[17] ? 18'(-x) : 18'(x);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
    if (x > 52'sd2147483647) sat32 = 32'sh7FFF_FFFF;
    else if (x < -52'sd2147483648) sat32 = 32'sh8000_0000;
    else sat32 = x[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] x);
    if (x > 50'sh0_7FFF_FFFF_FFFF) sat48 = 48'sh7FFF_FFFF_FFFF;
    else if (x < -50'sh0_8000_0000_0000) sat48 = 48'sh8000_0000_0000;
    else sat48 = x[47:0];
  endfunction

  function automatic logic signed [50:0] shr16(input logic signed [50:0] x);
    logic signed [50:0] nx;
    nx = -x;
    shr16 = x[50] ? -(nx >>> 16) : (x >>> 16);
  endfunction

  state_e             state_q, state_d;
  logic               run_q, run_d;
  logic [1:0]         idx_q, idx_d;
  logic signed [31:0] own_pos_q [3], own_pos_d [3];
  logic signed [31:0] own_vel_q [3], own_vel_d [3];
  logic signed [17:0] own_nrm_q [3], own_nrm_d [3];
  logic signed [47:0] fsum_q [3], fsum_d [3];
  logic [31:0]        omag_q [3], omag_d [3];
  logic               opos_q [3], opos_d [3];
  logic [63:0]        acc_q, acc_d, t_q, t_d, g_q, g_d;
  logic [31:0]        dd_q, dd_d, len_q, len_d;
  logic [16:0]        x_q, x_d;
  logic signed [31:0] v_q [3], v_d [3], vt_q [3], vt_d [3];
  logic signed [50:0] dot_q, dot_d;
  logic [46:0]        pmag_q [3], pmag_d [3], ms_q [3], ms_d [3];
  logic               pneg_q [3], pneg_d [3];
  logic               shifted_q, shifted_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] out_pos_q [3], out_pos_d [3], out_vel_q [3], out_vel_d [3];

  arith_req_t         ar_req;
  arith_rsp_t         ar_rsp;
  logic [95:0]        prod;
  logic signed [31:0] it_pos [3];
  logic signed [32:0] off [3];
  logic [32:0]        offm [3];
  logic               nb_skip, adv, big;
  logic [46:0]        m47;
  logic signed [49:0] fs_sum, vel_t, v_sum;
  logic signed [50:0] dot_sum;
  logic signed [51:0] vt_diff;
  logic signed [51:0] pos_sum [3];

  pri_arith u_arith (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (ar_req),
    .rsp_o (ar_rsp)
  );

  assign prod      = ar_rsp.res;
  assign it_pos[0] = item_i.pos_x;
  assign it_pos[1] = item_i.pos_y;
  assign it_pos[2] = item_i.pos_z;

  always_comb begin
    nb_skip = cfg_i.radius == '0;
    big     = 1'b0;
    for (int i = 0; i < 3; i++) begin
      off[i]  = {it_pos[i][31], it_pos[i]} - {own_pos_q[i][31], own_pos_q[i]};
      offm[i] = off[i][32] ? 33'(-off[i]) : 33'(off[i]);
      if (offm[i] >= {2'b00, cfg_i.radius}) nb_skip = 1'b1;
      if (ms_q[i][46:31] != '0) big = 1'b1;
      pos_sum[i] = {{20{own_pos_q[i][31]}}, own_pos_q[i]} +
                   (pneg_q[i] ? -$signed({5'b0, pmag_q[i]}) : $signed({5'b0, pmag_q[i]}));
    end
  end

  assign m47    = (prod[95:63] != '0) ? {47{1'b1}} : prod[62:16];
  assign fs_sum = $signed({{2{fsum_q[idx_q][47]}}, fsum_q[idx_q]}) +
                  (opos_q[idx_q] ? -$signed({3'b0, m47}) : $signed({3'b0, m47}));
  assign vel_t  = own_vel_q[idx_q][31] ? -$signed({17'b0, prod[48:16]}) :
                                         $signed({17'b0, prod[48:16]});
  assign v_sum  = vel_t + $signed({{2{fsum_q[idx_q][47]}}, fsum_q[idx_q]});
  assign dot_sum = dot_q + ((v_q[idx_q][31] ^ own_nrm_q[idx_q][17]) ?
                            -$signed({2'b0, prod[48:0]}) : $signed({2'b0, prod[48:0]}));
  assign vt_diff = $signed({{20{v_q[idx_q][31]}}, v_q[idx_q]}) -
                   ((dot_q[50] ^ own_nrm_q[idx_q][17]) ? -$signed({4'b0, prod[63:16]}) :
                                                         $signed({4'b0, prod[63:16]}));

  always_comb begin
    state_d     = state_q;
    run_d       = run_q;
    idx_d       = idx_q;
    own_pos_d   = own_pos_q;
    own_vel_d   = own_vel_q;
    own_nrm_d   = own_nrm_q;
    fsum_d      = fsum_q;
    omag_d      = omag_q;
    opos_d      = opos_q;
    acc_d       = acc_q;
    t_d         = t_q;
    g_d         = g_q;
    dd_d        = dd_q;
    len_d       = len_q;
    x_d         = x_q;
    v_d         = v_q;
    vt_d        = vt_q;
    dot_d       = dot_q;
    pmag_d      = pmag_q;
    ms_d        = ms_q;
    pneg_d      = pneg_q;
    shifted_d   = shifted_q;
    out_valid_d = out_valid_q;
    out_pos_d   = out_pos_q;
    out_vel_d   = out_vel_q;
    ar_req      = '0;
    item_ready_o = 1'b0;
    adv         = 1'b0;

    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_ready_o = 1'b1;
          idx_d = '0;
          unique case (item_i.kind)
            KIND_BEGIN: begin
              own_pos_d[0] = item_i.pos_x;
              own_pos_d[1] = item_i.pos_y;
              own_pos_d[2] = item_i.pos_z;
              own_vel_d[0] = item_i.vel_x;
              own_vel_d[1] = item_i.vel_y;
              own_vel_d[2] = item_i.vel_z;
              own_nrm_d[0] = item_i.norm_x;
              own_nrm_d[1] = item_i.norm_y;
              own_nrm_d[2] = item_i.norm_z;
              for (int i = 0; i < 3; i++) fsum_d[i] = '0;
            end
            KIND_NEIGHBOR: begin
              for (int i = 0; i < 3; i++) begin
                omag_d[i] = offm[i][31:0];
                opos_d[i] = !off[i][32] && (off[i] != '0);
              end
              acc_d = '0;
              if (!nb_skip) state_d = ST_N_SQ;
            end
            default: state_d = ST_F_VEL;
          endcase
        end
      end
      ST_N_SQ: begin
        if (!run_q) begin
          ar_req = '{start: 1'b1, op: ARITH_MUL, a: {32'd0, omag_q[idx_q]},
                     b: {32'd0, omag_q[idx_q]}};
          run_d = 1'b1;
        end else if (ar_rsp.done) begin
          run_d = 1'b0;
          acc_d = acc_q + prod[63:0];
          adv = 1'b1;
        end
        if (adv) begin
          if (idx_q == 2'd2) begin
            idx_d = '0;
            state_d = ST_N_RR;
          end else idx_d = idx_q + 2'd1;
        end
      end
      ST_N_RR: begin
        if (!run_q) begin
          ar_req = '{start: 1'b1, op: ARITH_MUL, a: {33'd0, cfg_i.radius},
                     b: {33'd0, cfg_i.radius}};
          run_d = 1'b1;
        end else if (ar_rsp.done) begin
          run_d = 1'b0;
          if (acc_q == '0 || acc_q >= prod[63:0]) state_d = ST_IDLE;
          else state_d = ST_N_SQRT;
        end
      end
      ST_N_SQRT: begin
        if (!run_q) begin
          ar_req = '{start: 1'b1, op: ARITH_SQRT, a: acc_q, b: 64'd0};
          run_d = 1'b1;
        end else if (ar_rsp.done) begin
          run_d = 1'b0;
          dd_d = prod[31:0];
          state_d = ST_N_X;
        end
      end
      ST_N_X: begin
        if (!run_q) begin
          ar_req = '{start: 1'b1, op: ARITH_DIV,
                     a: {17'd0, 31'(cfg_i.radius - dd_q[30:0]), 16'd0},
                     b: {33'd0, cfg_i.radius}};
          run_d = 1'b1;
        end else if (ar_rsp.done) begin
          run_d = 1'b0;
          x_d = prod[16:0];
          state_d = ST_N_KX;
        end
      end
      ST_N_KX: begin
        if (!run_q) begin
          ar_req = '{start: 1'b1, op: ARITH_MUL, a: {33'd0, cfg_i.strength},
                     b: {47'd0, x_q}};
          run_d = 1'b1;
        end else if (ar_rsp.done) begin
          run_d = 1'b0;
          t_d = prod[63:0];
          state_d = ST_N_KXX;
        end
      end
      ST_N_KXX: begin
        if (!run_q) begin
          ar_req = '{start: 1'b1, op: ARITH_MUL, a: t_q, b: {47'd0, x_q}};
          run_d = 1'b1;
        end else if (ar_rsp.done) begin
          run_d = 1'b0;
          t_d = prod[63:0];
          state_d = ST_N_G;
        end
      end
      ST_N_G: begin
        if (!run_q) begin
          ar_req = '{start: 1'b1, op: ARITH_DIV, a: t_q, b: acc_q};
          run_d = 1'b1;
        end else if (ar_rsp.done) begin
          run_d = 1'b0;
          g_d = prod[63:0];
          idx_d = '0;
          state_d = ST_N_ACC;
        end
      end
      ST_N_ACC: begin
        if (omag_q[idx_q] == '0 || g_q == '0) adv = 1'b1;
        else if (!run_q) begin
          ar_req = '{start: 1'b1, op: ARITH_MUL, a: g_q, b: {32'd0, omag_q[idx_q]}};
          run_d = 1'b1;
        end else if (ar_rsp.done) begin
          run_d = 1'b0;
          fsum_d[idx_q] = sat48(fs_sum);
          adv = 1'b1;
        end
        if (adv) begin
          if (idx_q == 2'd2) begin
            idx_d = '0;
            state_d = ST_IDLE;
          end else idx_d = idx_q + 2'd1;
        end
      end
      ST_F_VEL: begin
        if (!run_q) begin
          ar_req = '{start: 1'b1, op: ARITH_MUL, a: {32'd0, mag32(own_vel_q[idx_q])},
                     b: {47'd0, cfg_i.damping}};
          run_d = 1'b1;
        end else if (ar_rsp.done) begin
          run_d = 1'b0;
          v_d[idx_q] = sat32({{2{v_sum[49]}}, v_sum});
          dot_d = '0;
          if (idx_q == 2'd2) begin
            idx_d = '0;
            state_d = ST_F_DOT;
          end else idx_d = idx_q + 2'd1;
        end
      end
      ST_F_DOT: begin
        if (!run_q) begin
          ar_req = '{start: 1'b1, op: ARITH_MUL, a: {32'd0, mag32(v_q[idx_q])},
                     b: {46'd0, mag18(own_nrm_q[idx_q])}};
          run_d = 1'b1;
        end else if (ar_rsp.done) begin
          run_d = 1'b0;
          if (idx_q == 2'd2) begin
            dot_d = shr16(dot_sum);
            idx_d = '0;
            state_d = ST_F_NRM;
          end else begin
            dot_d = dot_sum;
            idx_d = idx_q + 2'd1;
          end
        end
      end
      ST_F_NRM: begin
        if (!run_q) begin
          ar_req = '{start: 1'b1, op: ARITH_MUL,
                     a: {13'd0, (dot_q[50] ? 51'(-dot_q) : 51'(dot_q))},
                     b: {46'd0, mag18(own_nrm_q[idx_q])}};
          run_d = 1'b1;
        end else if (ar_rsp.done) begin
          run_d = 1'b0;
          vt_d[idx_q] = sat32(vt_diff);
          state_d = ST_F_P;
        end
      end
      ST_F_P: begin
        if (!run_q) begin
          ar_req = '{start: 1'b1, op: ARITH_MUL, a: {33'd0, cfg_i.step_dt},
                     b: {32'd0, mag32(vt_q[idx_q])}};
          run_d = 1'b1;
        end else if (ar_rsp.done) begin
          run_d = 1'b0;
          pmag_d[idx_q] = prod[62:16];
          ms_d[idx_q]   = prod[62:16];
          pneg_d[idx_q] = vt_q[idx_q][31];
          if (idx_q == 2'd2) begin
            idx_d = '0;
            shifted_d = 1'b0;
            state_d = ST_F_SHIFT;
          end else begin
            idx_d = idx_q + 2'd1;
            state_d = ST_F_NRM;
          end
        end
      end
      ST_F_SHIFT: begin
        if (big) begin
          for (int i = 0; i < 3; i++) ms_d[i] = ms_q[i] >> 1;
          shifted_d = 1'b1;
        end else begin
          acc_d = '0;
          idx_d = '0;
          state_d = ST_F_LEN;
        end
      end
      ST_F_LEN: begin
        if (!run_q) begin
          ar_req = '{start: 1'b1, op: ARITH_MUL, a: {32'd0, ms_q[idx_q][31:0]},
                     b: {32'd0, ms_q[idx_q][31:0]}};
          run_d = 1'b1;
        end else if (ar_rsp.done) begin
          run_d = 1'b0;
          acc_d = acc_q + prod[63:0];
          if (idx_q == 2'd2) begin
            idx_d = '0;
            state_d = ST_F_LIM;
          end else idx_d = idx_q + 2'd1;
        end
      end
      ST_F_LIM: begin
        if (!run_q) begin
          ar_req = '{start: 1'b1, op: ARITH_MUL, a: {33'd0, cfg_i.max_step},
                     b: {33'd0, cfg_i.max_step}};
          run_d = 1'b1;
        end else if (ar_rsp.done) begin
          run_d = 1'b0;
          if (shifted_q || acc_q > prod[63:0]) state_d = ST_F_SQRT;
          else state_d = ST_F_OUT;
        end
      end
      ST_F_SQRT: begin
        if (!run_q) begin
          ar_req = '{start: 1'b1, op: ARITH_SQRT, a: acc_q, b: 64'd0};
          run_d = 1'b1;
        end else if (ar_rsp.done) begin
          run_d = 1'b0;
          len_d = prod[31:0];
          idx_d = '0;
          if (prod[31:0] == '0) begin
            for (int i = 0; i < 3; i++) pmag_d[i] = '0;
            state_d = ST_F_OUT;
          end else state_d = ST_F_SC;
        end
      end
      ST_F_SC: begin
        if (!run_q) begin
          ar_req = '{start: 1'b1, op: ARITH_MUL, a: {32'd0, ms_q[idx_q][31:0]},
                     b: {33'd0, cfg_i.max_step}};
          run_d = 1'b1;
        end else if (ar_rsp.done) begin
          run_d = 1'b0;
          t_d = prod[63:0];
          state_d = ST_F_DIV;
        end
      end
      ST_F_DIV: begin
        if (!run_q) begin
          ar_req = '{start: 1'b1, op: ARITH_DIV, a: t_q, b: {32'd0, len_q}};
          run_d = 1'b1;
        end else if (ar_rsp.done) begin
          run_d = 1'b0;
          pmag_d[idx_q] = prod[46:0];
          if (idx_q == 2'd2) begin
            idx_d = '0;
            state_d = ST_F_OUT;
          end else begin
            idx_d = idx_q + 2'd1;
            state_d = ST_F_SC;
          end
        end
      end
      ST_F_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          for (int i = 0; i < 3; i++) begin
            out_pos_d[i] = sat32(pos_sum[i]);
            out_vel_d[i] = vt_q[i];
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        own_pos_q[i] <= '0;
        own_vel_q[i] <= '0;
        own_nrm_q[i] <= '0;
        fsum_q[i]    <= '0;
      end
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      own_pos_q   <= own_pos_d;
      own_vel_q   <= own_vel_d;
      own_nrm_q   <= own_nrm_d;
      fsum_q      <= fsum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    omag_q    <= omag_d;
    opos_q    <= opos_d;
    acc_q     <= acc_d;
    t_q       <= t_d;
    g_q       <= g_d;
    dd_q      <= dd_d;
    len_q     <= len_d;
    x_q       <= x_d;
    v_q       <= v_d;
    vt_q      <= vt_d;
    dot_q     <= dot_d;
    pmag_q    <= pmag_d;
    ms_q      <= ms_d;
    pneg_q    <= pneg_d;
    shifted_q <= shifted_d;
    out_pos_q <= out_pos_d;
    out_vel_q <= out_vel_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.new_pos_x = out_pos_q[0];
  assign out_o.new_pos_y = out_pos_q[1];
  assign out_o.new_pos_z = out_pos_q[2];
  assign out_o.new_vel_x = out_vel_q[0];
  assign out_o.new_vel_y = out_vel_q[1];
  assign out_o.new_vel_z = out_vel_q[2];

  a_no_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ar_req.start |-> !ar_rsp.busy)
    else $error("arith unit started while busy");

  a_out_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_F_OUT && out_valid_q && !out_o.ready) |=> state_q == ST_F_OUT)
    else $error("result overwrote a pending output item");

endmodule

[rtl/core/particle_repulsion_integrate.sv]
// ----------------------------------------------------------------------------
// particle_repulsion_integrate
// One Q16.16 repulsion relaxation substep per particle, with a queued front.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake      Payload
// in_i     in   valid/ready    kind, pos_xyz, vel_xyz, norm_xyz
// out_o    out  valid/ready    new_pos_xyz, new_vel_xyz
// cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// A begin item only loads the particle's own state and clears the force sums. The
// shared bit-serial unit carries out every multiply, root and divide: a neighbor out
// of range is rejected before the root, and a finish whose step is limited adds a
// root and divides. Reset is asynchronous with no clearing pass.
// The four-entry queue accepts items while the back end works or a result waits.
// ----------------------------------------------------------------------------
module particle_repulsion_integrate import pri_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pri_in_if.sink      in_i,
  pri_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i
);

  cfg_t  cfg_q;
  logic  item_valid, item_ready;
  item_t item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius   <= RADIUS_RST;
      cfg_q.strength <= STRENGTH_RST;
      cfg_q.damping  <= DAMPING_RST;
      cfg_q.step_dt  <= STEP_DT_RST;
      cfg_q.max_step <= MAX_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIUS:   cfg_q.radius   <= cfg_data_i;
        REG_STRENGTH: cfg_q.strength <= cfg_data_i;
        REG_DAMPING:  cfg_q.damping  <= cfg_data_i[16:0];
        REG_STEP_DT:  cfg_q.step_dt  <= cfg_data_i;
        REG_MAX_STEP: cfg_q.max_step <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pri_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .item_valid_o(item_valid),
    .item_o      (item),
    .item_ready_i(item_ready)
  );

  pri_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_valid_i(item_valid),
    .item_i      (item),
    .item_ready_o(item_ready),
    .out_o       (out_o)
  );

endmodule

[tb/particle_repulsion_integrate_test.sv]
// ----------------------------------------------------------------------------
// particle_repulsion_integrate_test
// Self-checking bench for the repulsion relaxation step. Particle sequences
// (begin, neighbors, finish) go in with random sender and receiver gaps. A
// Q16.16 motion predictor computes each finish result, and every result is
// checked in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module particle_repulsion_integrate_test;
  import pri_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam longint MAX48 = 64'sh7FFF_FFFF_FFFF;
  localparam longint MIN48 = -MAX48 - 1;
  localparam longint unsigned MASK31 = 64'h7FFF_FFFF;
  localparam int LIMIT = 4000000;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] pos[3];
    logic signed [31:0] vel[3];
    logic signed [17:0] nrm[3];
  } particle_item_t;

  typedef logic [5:0][31:0] motion_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [30:0] cfg_data;

  pri_in_if  in_ch();
  pri_out_if out_ch();

  particle_repulsion_integrate dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always #4 clk_i = ~clk_i;

  longint unsigned radius, strength, damping, step_dt, max_step;
  longint own_pos[3], own_vel[3], own_nrm[3], force_sum[3];
  motion_t expected_motion[$];
  int  send_idle, recv_idle, hold_stretch, mismatches, cycles;

  function automatic longint trunc16(longint x);
    return x >= 0 ? (x >>> 16) : -((-x) >>> 16);
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint sat32(longint x);
    return clip(x, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint unsigned magn(longint x);
    return x < 0 ? longint'(-x) : x;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic apply_repulsion(particle_item_t it);
    longint o[3];
    longint unsigned d2, d, x, n, g, a, m;
    d2 = 0;
    if (radius == 0) return;
    for (int i = 0; i < 3; i++) begin
      o[i] = longint'(it.pos[i]) - own_pos[i];
      if (magn(o[i]) >= radius) return;
    end
    for (int i = 0; i < 3; i++) d2 += magn(o[i]) * magn(o[i]);
    if (d2 == 0 || d2 >= radius * radius) return;
    d = int_sqrt(d2);
    x = ((radius - d) << 16) / radius;
    n = strength * x * x;
    g = n / d2;
    for (int i = 0; i < 3; i++) begin
      a = magn(o[i]);
      if (a == 0 || g == 0) continue;
      if (g > 64'hFFFF_FFFF_FFFF_FFFF / a) m = MAX48;
      else begin
        m = (g * a) >> 16;
        if (m > MAX48) m = MAX48;
      end
      force_sum[i] = clip(force_sum[i] + (o[i] > 0 ? -longint'(m) : longint'(m)), MIN48, MAX48);
    end
  endtask

  function automatic motion_t integrate_motion();
    longint v[3], vt[3], p[3], dot, mm;
    longint unsigned ms[3], len2, len;
    int s;
    motion_t r;
    dot = 0;
    len2 = 0;
    s = 0;
    for (int i = 0; i < 3; i++)
      v[i] = sat32(trunc16(own_vel[i] * longint'(damping)) + force_sum[i]);
    for (int i = 0; i < 3; i++) dot += v[i] * own_nrm[i];
    dot = trunc16(dot);
    for (int i = 0; i < 3; i++) begin
      vt[i] = sat32(v[i] - trunc16(dot * own_nrm[i]));
      p[i] = trunc16(longint'(step_dt) * vt[i]);
    end
    while ((magn(p[0]) >> s) > MASK31 || (magn(p[1]) >> s) > MASK31 ||
           (magn(p[2]) >> s) > MASK31) s++;
    for (int i = 0; i < 3; i++) begin
      ms[i] = magn(p[i]) >> s;
      len2 += ms[i] * ms[i];
    end
    if (s > 0 || len2 > max_step * max_step) begin
      len = int_sqrt(len2);
      for (int i = 0; i < 3; i++) begin
        mm = len != 0 ? longint'((ms[i] * max_step) / len) : 0;
        p[i] = p[i] < 0 ? -mm : mm;
      end
    end
    for (int i = 0; i < 3; i++) begin
      r[i] = 32'(sat32(own_pos[i] + p[i]));
      r[3 + i] = 32'(vt[i]);
    end
    return r;
  endfunction

  task automatic predict(particle_item_t it);
    case (it.kind)
      KIND_BEGIN: begin
        for (int i = 0; i < 3; i++) begin
          own_pos[i] = it.pos[i];
          own_vel[i] = it.vel[i];
          own_nrm[i] = it.nrm[i];
          force_sum[i] = 0;
        end
      end
      KIND_NEIGHBOR: apply_repulsion(it);
      KIND_FINISH: expected_motion.insert(expected_motion.size(), integrate_motion());
      default: ;
    endcase
  endtask

  task automatic send_item(particle_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.kind   <= it.kind;
    in_ch.pos_x  <= it.pos[0];
    in_ch.pos_y  <= it.pos[1];
    in_ch.pos_z  <= it.pos[2];
    in_ch.vel_x  <= it.vel[0];
    in_ch.vel_y  <= it.vel[1];
    in_ch.vel_z  <= it.vel[2];
    in_ch.norm_x <= it.nrm[0];
    in_ch.norm_y <= it.nrm[1];
    in_ch.norm_z <= it.nrm[2];
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_motion.size() != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, longint unsigned value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[30:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_RADIUS:   radius   = value & MASK31;
      REG_STRENGTH: strength = value & MASK31;
      REG_DAMPING:  damping  = value & 64'h1FFFF;
      REG_STEP_DT:  step_dt  = value & MASK31;
      REG_MAX_STEP: max_step = value & MASK31;
      default: ;
    endcase
  endtask

  task automatic configure(longint unsigned r, longint unsigned k, longint unsigned dmp,
                           longint unsigned dt, longint unsigned ms);
    drain();
    write_reg(REG_RADIUS, r);
    write_reg(REG_STRENGTH, k);
    write_reg(REG_DAMPING, dmp);
    write_reg(REG_STEP_DT, dt);
    write_reg(REG_MAX_STEP, ms);
  endtask

  function automatic particle_item_t make_item(logic [1:0] kind, longint px, longint py,
                                               longint pz, longint vx, longint vy,
                                               longint vz, int nx, int ny, int nz);
    particle_item_t it;
    it.kind = kind;
    it.pos[0] = 32'(px); it.pos[1] = 32'(py); it.pos[2] = 32'(pz);
    it.vel[0] = 32'(vx); it.vel[1] = 32'(vy); it.vel[2] = 32'(vz);
    it.nrm[0] = 18'(nx); it.nrm[1] = 18'(ny); it.nrm[2] = 18'(nz);
    return it;
  endfunction

  function automatic longint rand_span(longint unsigned span);
    return longint'({$urandom, $urandom} % (2 * span + 1)) - longint'(span);
  endfunction

  function automatic particle_item_t random_item(logic [1:0] kind);
    particle_item_t it;
    it.kind = kind;
    for (int i = 0; i < 3; i++) begin
      it.pos[i] = $urandom;
      it.vel[i] = $urandom;
      it.nrm[i] = 18'($urandom);
    end
    return it;
  endfunction

  task automatic send_particle(int neighbors, bit wide);
    particle_item_t it;
    longint unsigned span;
    it = random_item(KIND_BEGIN);
    for (int i = 0; i < 3; i++) begin
      if (!wide) begin
        it.pos[i] = 32'(rand_span(64'd1 << 22));
        it.vel[i] = 32'(rand_span(64'd1 << 20));
      end
      it.nrm[i] = 18'($urandom_range(3) == 0 ? longint'($urandom) : rand_span(46341));
    end
    send_item(it);
    span = radius + radius / 4 + 1;
    for (int j = 0; j < neighbors; j++) begin
      it.kind = KIND_NEIGHBOR;
      for (int i = 0; i < 3; i++)
        it.pos[i] = 32'($urandom_range(9) == 0 ? longint'($urandom) :
                        own_pos[i] + rand_span(span));
      send_item(it);
    end
    it = random_item(KIND_FINISH);
    send_item(it);
    if ($urandom_range(7) == 0) send_item(it);
  endtask

  task automatic test_directed();
    send_item(make_item(KIND_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_NEIGHBOR, 1000, -1000, 500, 0, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_UNUSED, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    send_item(make_item(KIND_BEGIN, 2147483647, -2147483648, 0, -2147483648, 2147483647,
                        1 << 20, -65536, 0, 0));
    send_item(make_item(KIND_NEIGHBOR, 2147483647, -2147483648, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_NEIGHBOR, 2147450000, -2147480000, 20000, 0, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_NEIGHBOR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_FINISH, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    send_item(make_item(KIND_BEGIN, -2147483648, 2147483647, -1, 2147483647, -2147483648,
                        -1, 65536, 131071, -131072));
    send_item(make_item(KIND_NEIGHBOR, -2147480000, 2147483647, 30000, 0, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_BEGIN, 65536, 0, 0, 300000, -300000, 65536, 0, 0, 65536));
    send_item(make_item(KIND_NEIGHBOR, 40000, 10000, -5000, 0, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_NEIGHBOR, 65536, 1, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_UNUSED, 65536, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_config_extremes();
    configure(MASK31, MASK31, 65536, MASK31, 0);
    repeat (3) send_particle(3, 1'b1);
    configure(0, 0, 0, 0, MASK31);
    repeat (3) send_particle(3, 1'b0);
    configure(1, MASK31, 1, 65536, 1);
    repeat (3) send_particle(3, 1'b0);
    configure(64'h7000_0000, 64'h4000_0000, 65536, 64'h7FFF_0000, 64'h7FFF_FFFF);
    repeat (3) send_particle(3, 1'b1);
  endtask

  task automatic test_random(int count, int s_idle, int r_idle);
    int sent;
    send_idle = s_idle;
    recv_idle = r_idle;
    sent = 0;
    while (sent < count) begin
      if (sent % 60 == 0)
        configure($urandom_range(32768, 8 << 16), $urandom_range(0, 4 << 16),
                  $urandom_range(0, 65536), $urandom_range(0, 65536),
                  $urandom_range(0, 2 << 16));
      if ($urandom_range(9) == 0) begin
        send_item(random_item(2'($urandom_range(3))));
        sent += 1;
      end else begin
        sent += 2;
        send_particle($urandom_range(0, 5), $urandom_range(7) == 0);
        sent += 3;
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    configure(4 << 16, 2 << 16, 60000, 6554, 65536);
    hold_stretch = 4000;
    repeat (4) send_particle(1, 1'b0);
    drain();
    repeat (2) send_particle(2, 1'b0);
  endtask

  always @(posedge clk_i) begin
    motion_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = {out_ch.new_vel_z, out_ch.new_vel_y, out_ch.new_vel_x,
             out_ch.new_pos_z, out_ch.new_pos_y, out_ch.new_pos_x};
      if (expected_motion.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item %h", got);
      end else begin
        want = expected_motion.pop_front();
        for (int i = 0; i < 6; i++)
          if (got[i] !== want[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Field %0d mismatch: expected %h, actual %h", i, want[i], got[i]);
          end
      end
    end
    if (hold_stretch > 0) begin
      hold_stretch--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= $urandom_range(99) >= recv_idle;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("particle_repulsion_integrate_test NOT OK");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
    in_ch.vel_x = '0; in_ch.vel_y = '0; in_ch.vel_z = '0;
    in_ch.norm_x = '0; in_ch.norm_y = '0; in_ch.norm_z = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    hold_stretch = 0;
    mismatches = 0;
    cycles = 0;
    send_idle = 0;
    recv_idle = 0;
    radius = 65536;
    strength = 65536;
    damping = 65536;
    step_dt = 6554;
    max_step = 65536;
    for (int i = 0; i < 3; i++) begin
      own_pos[i] = 0; own_vel[i] = 0; own_nrm[i] = 0; force_sum[i] = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random(300, 9, 86);
    test_random(300, 86, 9);
    test_random(300, 0, 0);
    test_backpressure();
    drain();
    if (mismatches == 0 && expected_motion.size() == 0) begin
      $display("particle_repulsion_integrate_test OK");
    end else begin
      $display("particle_repulsion_integrate_test NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/pri_pkg.sv
rtl/core/pri_if.sv
rtl/core/pri_arith.sv
rtl/core/pri_front.sv
rtl/core/pri_back.sv
rtl/core/particle_repulsion_integrate.sv
tb/particle_repulsion_integrate_test.sv
